/* hw/rtl/screen_space_nearest_point_pick_unit_macros.svh */
// Assertion macros for the screen space nearest point pick unit.
// Included by modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef SCREEN_SPACE_NEAREST_POINT_PICK_UNIT_MACROS_SVH
`define SCREEN_SPACE_NEAREST_POINT_PICK_UNIT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define SSNPP_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("ssnpp assertion failed");

// trigger at one edge implies outcome at the next
`define SSNPP_ASSERT_NEXT(label, trig, outcome) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (outcome)) \
    else $error("ssnpp assertion failed");

`endif

/* hw/rtl/ssnpp_pkg.sv */
// Shared types, widths and constants of the nearest point pick unit.
// No dependencies; used by every module of the block.
package ssnpp_pkg;

  localparam int MAX_POINTS = 1048576;
  localparam int CNT_W      = 21;
  localparam int IDX_W      = 20;
  localparam int COORD_W    = 24;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = 40;
  localparam int ACC_W      = 42;
  localparam int SUM_W      = 43;
  localparam int MAG_W      = 42;
  localparam int HALF_W     = 21;
  localparam int SIZE_W     = 14;
  localparam int CUR_W      = 13;
  localparam int NPROD_W    = 35;
  localparam int NUM_W      = 59;
  localparam int REM_W      = 42;
  localparam int SX_W       = 21;
  localparam int D_W        = 18;
  localparam int SQ_W       = 33;
  localparam int DIST_W     = 24;
  localparam int STEP_W     = 6;
  localparam int Q_DEPTH    = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;
  localparam int CFG_IDX_W  = 3;

  localparam logic [DIST_W-1:0] DIST_SAT  = 24'd16646399;
  localparam logic [DIST_W-1:0] DIST_NONE = 24'hFFFFFF;
  localparam logic signed [SX_W-1:0] DELTA_CLAMP = 21'sd65536;
  localparam logic signed [COORD_W-1:0] ONE_Q12 = 24'sd4096;
  localparam int SX_LIM_BIT = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_W  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CUR_X  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CUR_Y  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd7;

  typedef struct packed {
    logic [63:0]        row_x;
    logic [63:0]        row_y;
    logic [63:0]        row_w;
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
    logic [CUR_W-1:0]   cur_x;
    logic [CUR_W-1:0]   cur_y;
    logic [7:0]         radius;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic                      last;
    logic                      live;
    logic [IDX_W-1:0]          idx;
  } item_t;

  // queue side band between front and back
  typedef struct packed {
    logic  nonempty;
    item_t head;
  } q_head_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_WCHK,
    ST_MULN,
    ST_DIV,
    ST_FIN,
    ST_SQ,
    ST_CMP,
    ST_END
  } state_t;

  function automatic logic signed [COEF_W-1:0] coef(input logic [63:0] row,
                                                     input logic [1:0] lane);
    logic signed [COEF_W-1:0] c;
    case (lane)
      2'd0:    c = row[15:0];
      2'd1:    c = row[31:16];
      2'd2:    c = row[47:32];
      default: c = row[63:48];
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/ssnpp_queue.sv */
// Short item queue between the front and back of the pick unit.
// Depends on ssnpp_pkg.
module ssnpp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ssnpp_pkg::item_t push_item,
  output logic             full,
  input  logic             pop,
  output ssnpp_pkg::q_head_t head
);

  ssnpp_pkg::item_t mem_r [ssnpp_pkg::Q_DEPTH];
  logic [ssnpp_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [ssnpp_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full          = (cnt_r == ssnpp_pkg::QCNT_W'(ssnpp_pkg::Q_DEPTH));
  assign head.nonempty = (cnt_r != '0);
  assign head.head     = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* hw/rtl/ssnpp_front.sv */
// Front of the pick unit: takes point requests, numbers them, flags overflow.
// Depends on ssnpp_pkg and ssnpp_queue.
module ssnpp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [71:0]         in_tdata,
  input  logic                in_tlast,
  input  logic                pop,
  output ssnpp_pkg::q_head_t  head
);

  logic [ssnpp_pkg::CNT_W-1:0] count_r;
  logic             full, accept, live;
  ssnpp_pkg::item_t item;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;
  assign live      = (count_r < ssnpp_pkg::CNT_W'(ssnpp_pkg::MAX_POINTS));

  always_comb begin
    item.px   = in_tdata[23:0];
    item.py   = in_tdata[47:24];
    item.pz   = in_tdata[71:48];
    item.last = in_tlast;
    item.live = live;
    item.idx  = count_r[ssnpp_pkg::IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      if (in_tlast) begin
        count_r <= '0;
      end else if (live) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  ssnpp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_item (item),
    .full      (full),
    .pop       (pop),
    .head      (head)
  );

endmodule

/* hw/rtl/ssnpp_back.sv */
// Back of the pick unit: projection, divide, distance, running minimum, result.
// Depends on ssnpp_pkg and the assertion macro header.
`include "screen_space_nearest_point_pick_unit_macros.svh"

module ssnpp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ssnpp_pkg::cfg_t    cfg,
  input  ssnpp_pkg::q_head_t head,
  output logic               pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [47:0]        out_tdata,
  output logic               out_tuser
);

  ssnpp_pkg::state_t state_r, state_nxt;
  logic [ssnpp_pkg::STEP_W-1:0] step_r, step_nxt;
  ssnpp_pkg::item_t item_r;

  logic signed [ssnpp_pkg::ACC_W-1:0]  cx_r, cy_r, cw_r;
  logic signed [ssnpp_pkg::PROD_W-1:0] prod_r;
  logic        [ssnpp_pkg::NPROD_W-1:0] nprod_r;
  logic        [ssnpp_pkg::MAG_W-1:0]  magx_r, magy_r;
  logic                                negx_r, negy_r;
  logic        [ssnpp_pkg::NUM_W-1:0]  numx_r, numy_r;
  logic        [ssnpp_pkg::REM_W-1:0]  remx_r, remy_r;
  logic signed [ssnpp_pkg::D_W-1:0]    dx_r, dy_r;
  logic        [ssnpp_pkg::SQ_W-1:0]   sqx_r, sqy_r;

  logic [ssnpp_pkg::DIST_W-1:0] best_dist_r;
  logic [ssnpp_pkg::IDX_W-1:0]  best_idx_r;
  logic                         have_r;

  logic                         out_valid_r;
  logic                         out_found_r;
  logic [ssnpp_pkg::IDX_W-1:0]  out_idx_r;
  logic [ssnpp_pkg::DIST_W-1:0] out_dist_r;

  // ---- MAC step decode: row in step[3:2], lane in step[1:0]
  logic [3:0] mac_prev;
  logic [63:0] mac_row;
  logic signed [ssnpp_pkg::COORD_W-1:0] mac_op;
  logic signed [ssnpp_pkg::PROD_W-1:0]  mac_prod;
  logic signed [ssnpp_pkg::ACC_W-1:0]   prod_ext;

  assign mac_prev = step_r[3:0] - 4'd1;
  assign prod_ext = ssnpp_pkg::ACC_W'(prod_r);

  always_comb begin
    case (step_r[3:2])
      2'd0:    mac_row = cfg.row_x;
      2'd1:    mac_row = cfg.row_y;
      default: mac_row = cfg.row_w;
    endcase
    case (step_r[1:0])
      2'd0:    mac_op = item_r.px;
      2'd1:    mac_op = item_r.py;
      2'd2:    mac_op = item_r.pz;
      default: mac_op = ssnpp_pkg::ONE_Q12;
    endcase
    mac_prod = ssnpp_pkg::coef(mac_row, step_r[1:0]) * mac_op;
  end

  // ---- numerator magnitudes
  logic signed [ssnpp_pkg::SUM_W-1:0] sumx, sumy;
  logic [ssnpp_pkg::SUM_W-1:0] absx, absy;
  assign sumx = ssnpp_pkg::SUM_W'(cx_r) + ssnpp_pkg::SUM_W'(cw_r);
  assign sumy = ssnpp_pkg::SUM_W'(cy_r) + ssnpp_pkg::SUM_W'(cw_r);
  assign absx = sumx[ssnpp_pkg::SUM_W-1] ? ssnpp_pkg::SUM_W'(-sumx) : sumx;
  assign absy = sumy[ssnpp_pkg::SUM_W-1] ? ssnpp_pkg::SUM_W'(-sumy) : sumy;

  // ---- size multiply: step[1] picks y, step[0] picks upper half
  logic [ssnpp_pkg::MAG_W-1:0]  nm_mag;
  logic [ssnpp_pkg::HALF_W-1:0] nm_half;
  logic [ssnpp_pkg::SIZE_W-1:0] nm_size;
  logic [ssnpp_pkg::NPROD_W-1:0] nm_prod;
  logic [ssnpp_pkg::STEP_W-1:0] nm_prev;
  logic [ssnpp_pkg::NUM_W-1:0]  nm_term;

  assign nm_prev = step_r - 1'b1;
  always_comb begin
    nm_mag  = step_r[1] ? magy_r : magx_r;
    nm_half = step_r[0] ? nm_mag[ssnpp_pkg::MAG_W-1:ssnpp_pkg::HALF_W]
                        : nm_mag[ssnpp_pkg::HALF_W-1:0];
    nm_size = step_r[1] ? cfg.height : cfg.width;
    nm_prod = ssnpp_pkg::NPROD_W'(nm_half) * ssnpp_pkg::NPROD_W'(nm_size);
    // times 8, and upper half sits HALF_W bits higher
    nm_term = nm_prev[0] ? (ssnpp_pkg::NUM_W'(nprod_r) << (ssnpp_pkg::HALF_W + 3))
                         : (ssnpp_pkg::NUM_W'(nprod_r) << 3);
  end

  // ---- restoring divide, one quotient bit per cycle, x and y side by side
  logic [ssnpp_pkg::REM_W-1:0] den, trialx, trialy;
  logic gex, gey;
  assign den    = ssnpp_pkg::REM_W'(cw_r);
  assign trialx = {remx_r[ssnpp_pkg::REM_W-2:0], numx_r[ssnpp_pkg::NUM_W-1]};
  assign trialy = {remy_r[ssnpp_pkg::REM_W-2:0], numy_r[ssnpp_pkg::NUM_W-1]};
  assign gex    = (trialx >= den);
  assign gey    = (trialy >= den);

  // ---- floor, saturate, offset by cursor, clamp
  function automatic logic signed [ssnpp_pkg::D_W-1:0] delta(
      input logic [ssnpp_pkg::NUM_W-1:0] q,
      input logic                        rem_nz,
      input logic                        neg,
      input logic [ssnpp_pkg::CUR_W-1:0] cur);
    logic                              big;
    logic [ssnpp_pkg::SX_W-1:0]        mag;
    logic signed [ssnpp_pkg::SX_W-1:0] s, d;
    big = |q[ssnpp_pkg::NUM_W-1:ssnpp_pkg::SX_LIM_BIT];
    mag = big ? (ssnpp_pkg::SX_W'(1) << ssnpp_pkg::SX_LIM_BIT)
              : ssnpp_pkg::SX_W'(q[ssnpp_pkg::SX_LIM_BIT-1:0]);
    if (neg && !big && rem_nz) begin
      mag = mag + 1'b1;
    end
    s = neg ? -$signed(mag) : $signed(mag);
    d = s - $signed(ssnpp_pkg::SX_W'({cur, 4'b0}));
    if (d > ssnpp_pkg::DELTA_CLAMP) begin
      d = ssnpp_pkg::DELTA_CLAMP;
    end else if (d < -ssnpp_pkg::DELTA_CLAMP) begin
      d = -ssnpp_pkg::DELTA_CLAMP;
    end
    return ssnpp_pkg::D_W'(d);
  endfunction

  logic signed [2*ssnpp_pkg::D_W-1:0] sqx_full, sqy_full;
  assign sqx_full = dx_r * dx_r;
  assign sqy_full = dy_r * dy_r;

  logic [ssnpp_pkg::SQ_W:0]     dsum;
  logic [ssnpp_pkg::DIST_W-1:0] pt_dist;
  assign dsum = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign pt_dist = (dsum > (ssnpp_pkg::SQ_W+1)'(ssnpp_pkg::DIST_SAT))
                   ? ssnpp_pkg::DIST_SAT : dsum[ssnpp_pkg::DIST_W-1:0];

  logic out_free, out_load;
  logic [15:0] rad_sq;
  logic [ssnpp_pkg::DIST_W-1:0] thr;
  assign out_free = !out_valid_r || out_tready;
  assign rad_sq   = 16'(cfg.radius) * 16'(cfg.radius);
  assign thr      = {rad_sq, 8'b0};

  // ---- sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    pop       = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ssnpp_pkg::ST_IDLE: begin
        if (head.nonempty) begin
          pop       = 1'b1;
          step_nxt  = '0;
          state_nxt = head.head.live ? ssnpp_pkg::ST_MAC : ssnpp_pkg::ST_END;
        end
      end
      ssnpp_pkg::ST_MAC: begin
        step_nxt = step_r + 1'b1;
        if (step_r == ssnpp_pkg::STEP_W'(12)) begin
          state_nxt = ssnpp_pkg::ST_WCHK;
        end
      end
      ssnpp_pkg::ST_WCHK: begin
        step_nxt  = '0;
        state_nxt = (cw_r > 0) ? ssnpp_pkg::ST_MULN : ssnpp_pkg::ST_END;
      end
      ssnpp_pkg::ST_MULN: begin
        step_nxt = step_r + 1'b1;
        if (step_r == ssnpp_pkg::STEP_W'(4)) begin
          step_nxt  = ssnpp_pkg::STEP_W'(ssnpp_pkg::NUM_W - 1);
          state_nxt = ssnpp_pkg::ST_DIV;
        end
      end
      ssnpp_pkg::ST_DIV: begin
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = ssnpp_pkg::ST_FIN;
        end
      end
      ssnpp_pkg::ST_FIN: state_nxt = ssnpp_pkg::ST_SQ;
      ssnpp_pkg::ST_SQ:  state_nxt = ssnpp_pkg::ST_CMP;
      ssnpp_pkg::ST_CMP: state_nxt = ssnpp_pkg::ST_END;
      ssnpp_pkg::ST_END: begin
        if (!item_r.last) begin
          state_nxt = ssnpp_pkg::ST_IDLE;
        end else if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ssnpp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ssnpp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssnpp_pkg::ST_IDLE;
      step_r      <= '0;
      have_r      <= 1'b0;
      best_dist_r <= ssnpp_pkg::DIST_NONE;
      best_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
        have_r      <= 1'b0;
        best_dist_r <= ssnpp_pkg::DIST_NONE;
        best_idx_r  <= '0;
      end else begin
        if (out_tready) begin
          out_valid_r <= 1'b0;
        end
        if (state_r == ssnpp_pkg::ST_CMP && (!have_r || pt_dist < best_dist_r)) begin
          have_r      <= 1'b1;
          best_dist_r <= pt_dist;
          best_idx_r  <= item_r.idx;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= head.head;
      cx_r   <= '0;
      cy_r   <= '0;
      cw_r   <= '0;
    end
    if (out_load) begin
      out_found_r <= have_r && (best_dist_r < thr);
      out_idx_r   <= have_r ? best_idx_r : '0;
      out_dist_r  <= have_r ? best_dist_r : ssnpp_pkg::DIST_SAT;
    end
    case (state_r)
      ssnpp_pkg::ST_MAC: begin
        prod_r <= mac_prod;
        if (step_r != '0) begin
          case (mac_prev[3:2])
            2'd0:    cx_r <= cx_r + prod_ext;
            2'd1:    cy_r <= cy_r + prod_ext;
            default: cw_r <= cw_r + prod_ext;
          endcase
        end
      end
      ssnpp_pkg::ST_WCHK: begin
        negx_r <= sumx[ssnpp_pkg::SUM_W-1];
        negy_r <= sumy[ssnpp_pkg::SUM_W-1];
        magx_r <= absx[ssnpp_pkg::MAG_W-1:0];
        magy_r <= absy[ssnpp_pkg::MAG_W-1:0];
        numx_r <= '0;
        numy_r <= '0;
      end
      ssnpp_pkg::ST_MULN: begin
        nprod_r <= nm_prod;
        remx_r  <= '0;
        remy_r  <= '0;
        if (step_r != '0) begin
          if (nm_prev[1]) begin
            numy_r <= numy_r + nm_term;
          end else begin
            numx_r <= numx_r + nm_term;
          end
        end
      end
      ssnpp_pkg::ST_DIV: begin
        numx_r <= {numx_r[ssnpp_pkg::NUM_W-2:0], gex};
        numy_r <= {numy_r[ssnpp_pkg::NUM_W-2:0], gey};
        remx_r <= gex ? (trialx - den) : trialx;
        remy_r <= gey ? (trialy - den) : trialy;
      end
      ssnpp_pkg::ST_FIN: begin
        dx_r <= delta(numx_r, |remx_r, negx_r, cfg.cur_x);
        dy_r <= delta(numy_r, |remy_r, negy_r, cfg.cur_y);
      end
      ssnpp_pkg::ST_SQ: begin
        sqx_r <= ssnpp_pkg::SQ_W'(sqx_full);
        sqy_r <= ssnpp_pkg::SQ_W'(sqy_full);
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_dist_r, out_idx_r};
  assign out_tuser  = out_found_r;

  `SSNPP_ASSERT(a_pop_nonempty, !pop || head.nonempty)
  `SSNPP_ASSERT(a_best_bounded, !have_r || best_dist_r <= ssnpp_pkg::DIST_SAT)
  `SSNPP_ASSERT_NEXT(a_div_done, state_r == ssnpp_pkg::ST_DIV && step_r == '0,
                     state_r == ssnpp_pkg::ST_FIN)
  `SSNPP_ASSERT_NEXT(a_pick_cleared, out_load, !have_r && out_valid_r)

endmodule

/* hw/rtl/screen_space_nearest_point_pick_unit.sv */
// Top level of the screen space nearest point pick unit: registers and wiring.
// Depends on ssnpp_pkg, ssnpp_front and ssnpp_back.
//
// Usage:
//  in_*  : one 3-D point per request; tdata = point_x, point_y, point_z (24 bits
//          each, lowest first); tlast marks the final point of a pick.
//  out_* : one result per pick, sent after the tlast point; tdata = point_index
//          (20 bits) then best_dist_sq (24 bits); tuser = found.
//  cfg_* : register writes (index, 64-bit data), always ready; write only while
//          no pick is in flight.
//  The back sequencer takes one point at a time: a projected point passes
//  through pop, MAC steps, w check, size-multiply steps, divide steps,
//  distance and compare, and end; a point behind the camera goes from the
//  w check to the end, and one beyond the point limit from the pop to the end.
//  A four-entry queue lets the front take requests while the back is busy.
//  out_tvalid for a pick rises once its tlast point and the points still
//  queued ahead of it have passed through the back sequencer.
//  Reset clears the pick state and queue and loads the default registers.
//  If out_tready is low the result is held and the sequencer stops at the
//  next pick end; the queue then fills and in_tready drops.
module screen_space_nearest_point_pick_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // point_x, point_y, point_z
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // point_index, best_dist_sq, zero pad
  output logic        out_tuser,  // found
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  ssnpp_pkg::cfg_t    cfg_r;
  ssnpp_pkg::q_head_t head;
  logic               pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_x  <= 64'd1024;
      cfg_r.row_y  <= 64'd1024 << 16;
      cfg_r.row_w  <= 64'd1024 << 48;
      cfg_r.width  <= 14'd1920;
      cfg_r.height <= 14'd1080;
      cfg_r.cur_x  <= '0;
      cfg_r.cur_y  <= '0;
      cfg_r.radius <= 8'd20;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ssnpp_pkg::CFG_ROW_X:  cfg_r.row_x  <= cfg_data;
        ssnpp_pkg::CFG_ROW_Y:  cfg_r.row_y  <= cfg_data;
        ssnpp_pkg::CFG_ROW_W:  cfg_r.row_w  <= cfg_data;
        ssnpp_pkg::CFG_WIDTH:  cfg_r.width  <= cfg_data[13:0];
        ssnpp_pkg::CFG_HEIGHT: cfg_r.height <= cfg_data[13:0];
        ssnpp_pkg::CFG_CUR_X:  cfg_r.cur_x  <= cfg_data[12:0];
        ssnpp_pkg::CFG_CUR_Y:  cfg_r.cur_y  <= cfg_data[12:0];
        ssnpp_pkg::CFG_RADIUS: cfg_r.radius <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  ssnpp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .pop       (pop),
    .head      (head)
  );

  ssnpp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* verif/screen_space_nearest_point_pick_unit_tb.sv */
// Self-checking testbench for screen_space_nearest_point_pick_unit.
// Drives point streams and register writes, predicts each pick result in-bench
// and compares it with the out stream; needs ssnpp_pkg and the unit's RTL.
module screen_space_nearest_point_pick_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 150;
  localparam int LONG_HOLD      = 400;
  localparam int PICK_MAX       = 1048576;
  localparam longint SAT_DIST   = 16646399;
  localparam longint CLAMP_D    = 65536;

  typedef struct {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic               last;
  } point_t;

  typedef struct {
    logic        found;
    logic [19:0] idx;
    logic [23:0] dist_sq;
  } pick_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  screen_space_nearest_point_pick_unit dut (.*);

  // register shadow
  logic [63:0] sh_row_x, sh_row_y, sh_row_w;
  logic [13:0] sh_width, sh_height;
  logic [12:0] sh_cur_x, sh_cur_y;
  logic [7:0]  sh_radius;

  // running pick state
  longint best_dist;
  int     best_idx;
  bit     have_cand;
  int     pt_count;

  point_t pending_points[$];
  pick_t  expected_picks[$];
  point_t cur_point;

  int  mismatches, picks_checked, points_sent, found_hits, watchdog;
  bit  idle_enable, long_hold_req, long_hold_done;
  int  long_hold_cnt, in_gap, out_gap;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint clip_val(logic [63:0] row, longint x, longint y, longint z);
    longint l0, l1, l2, l3;
    l0 = longint'($signed(row[15:0]));
    l1 = longint'($signed(row[31:16]));
    l2 = longint'($signed(row[47:32]));
    l3 = longint'($signed(row[63:48]));
    return l0 * x + l1 * y + l2 * z + l3 * 4096;
  endfunction

  function automatic longint floor_quot(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic longint clamp_delta(longint d);
    if (d > CLAMP_D) return CLAMP_D;
    if (d < -CLAMP_D) return -CLAMP_D;
    return d;
  endfunction

  // advances the pick state by one accepted point, queues a result on tlast
  function automatic void project_and_pick(point_t p);
    longint x, y, z, cw, cx, cy, sx, sy, dx, dy, d, thr;
    pick_t r;
    x = longint'(p.px);
    y = longint'(p.py);
    z = longint'(p.pz);
    if (pt_count < PICK_MAX) begin
      cw = clip_val(sh_row_w, x, y, z);
      if (cw > 0) begin
        cx = clip_val(sh_row_x, x, y, z);
        cy = clip_val(sh_row_y, x, y, z);
        sx = floor_quot((cx + cw) * longint'(sh_width) * 8, cw);
        sy = floor_quot((cy + cw) * longint'(sh_height) * 8, cw);
        dx = clamp_delta(sx - longint'(sh_cur_x) * 16);
        dy = clamp_delta(sy - longint'(sh_cur_y) * 16);
        d = dx * dx + dy * dy;
        if (d > SAT_DIST) d = SAT_DIST;
        if (!have_cand || d < best_dist) begin
          best_dist = d;
          best_idx = pt_count;
          have_cand = 1'b1;
        end
      end
      pt_count++;
    end
    if (p.last) begin
      thr = longint'(sh_radius) * longint'(sh_radius) * 256;
      if (have_cand) begin
        r.found = best_dist < thr;
        r.idx = best_idx[19:0];
        r.dist_sq = best_dist[23:0];
      end else begin
        r.found = 1'b0;
        r.idx = '0;
        r.dist_sq = SAT_DIST[23:0];
      end
      expected_picks.push_back(r);
      best_dist = 64'hFFFFFF;
      best_idx = 0;
      have_cand = 1'b0;
      pt_count = 0;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tlast <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        project_and_pick(cur_point);
        points_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_points.size() > 0) begin
          cur_point = pending_points.pop_front();
          in_tdata <= {cur_point.pz, cur_point.py, cur_point.px};
          in_tlast <= cur_point.last;
          in_tvalid <= 1'b1;
          if (idle_enable && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 6);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pick_t want;
    logic [19:0] got_idx;
    logic [23:0] got_dist;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_idx = out_tdata[19:0];
        got_dist = out_tdata[43:20];
        if (expected_picks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: found=%0b idx=%0d dist=%0d",
                     out_tuser, got_idx, got_dist);
        end else begin
          want = expected_picks.pop_front();
          picks_checked++;
          if (want.found) found_hits++;
          if (out_tuser !== want.found || got_idx !== want.idx ||
              got_dist !== want.dist_sq) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pick %0d: expected found=%0b idx=%0d dist=%0d, got found=%0b idx=%0d dist=%0d",
                       picks_checked, want.found, want.idx, want.dist_sq,
                       out_tuser, got_idx, got_dist);
          end
        end
      end
      if (long_hold_req && !long_hold_done) begin
        long_hold_cnt++;
        if (long_hold_cnt >= LONG_HOLD) long_hold_done = 1'b1;
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        if (idle_enable && $urandom_range(0, 9) == 0) out_gap = $urandom_range(1, 6);
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      watchdog = 0;
    end else begin
      watchdog++;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", watchdog);
        $display("screen_space_nearest_point_pick_unit verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ssnpp_pkg::CFG_ROW_X:  sh_row_x = d;
      ssnpp_pkg::CFG_ROW_Y:  sh_row_y = d;
      ssnpp_pkg::CFG_ROW_W:  sh_row_w = d;
      ssnpp_pkg::CFG_WIDTH:  sh_width = d[13:0];
      ssnpp_pkg::CFG_HEIGHT: sh_height = d[13:0];
      ssnpp_pkg::CFG_CUR_X:  sh_cur_x = d[12:0];
      ssnpp_pkg::CFG_CUR_Y:  sh_cur_y = d[12:0];
      ssnpp_pkg::CFG_RADIUS: sh_radius = d[7:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [63:0] rx, logic [63:0] ry, logic [63:0] rw,
                           int w, int h, int cx, int cy, int rad);
    write_reg(ssnpp_pkg::CFG_ROW_X, rx);
    write_reg(ssnpp_pkg::CFG_ROW_Y, ry);
    write_reg(ssnpp_pkg::CFG_ROW_W, rw);
    write_reg(ssnpp_pkg::CFG_WIDTH, 64'(w));
    write_reg(ssnpp_pkg::CFG_HEIGHT, 64'(h));
    write_reg(ssnpp_pkg::CFG_CUR_X, 64'(cx));
    write_reg(ssnpp_pkg::CFG_CUR_Y, 64'(cy));
    write_reg(ssnpp_pkg::CFG_RADIUS, 64'(rad));
  endtask

  // sender pause: everything sent and answered, then let the back end settle
  task automatic wait_drained();
    while (pending_points.size() > 0 || in_tvalid || expected_picks.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_point(int x, int y, int z, bit last);
    point_t p;
    p.px = x[23:0];
    p.py = y[23:0];
    p.pz = z[23:0];
    p.last = last;
    pending_points.push_back(p);
  endtask

  function automatic int rand_coord(int spread);
    case ($urandom_range(0, 5))
      0:       return $urandom;                      // full 24-bit range
      1:       return $urandom_range(0, 1) ? 8388607 : -8388608;
      default: return $urandom_range(0, 2 * spread) - spread;
    endcase
  endfunction

  function automatic logic [63:0] rand_row(bit w_row, int mode);
    logic [63:0] r;
    case (mode)
      0: r = {$urandom, $urandom};
      1: begin
        r[15:0] = 16'($urandom_range(0, 400) - 200);
        r[31:16] = 16'($urandom_range(0, 400) - 200);
        r[47:32] = 16'($urandom_range(0, 400) - 200);
        r[63:48] = w_row ? 16'($urandom_range(256, 32767))
                         : 16'($urandom_range(0, 2048) - 1024);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic random_phase(int n_items, int spread);
    int mode, w, h, left;
    mode = $urandom_range(0, 3);
    w = $urandom_range(1, 128);
    h = $urandom_range(1, 128);
    if (mode == 0) begin
      write_all(rand_row(0, 0), rand_row(0, 0), rand_row(1, 0),
                $urandom_range(1, 8192), $urandom_range(1, 8192),
                $urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(1, 255));
    end else if (mode == 1) begin
      write_all(rand_row(0, 1), rand_row(0, 1), rand_row(1, 1), w, h,
                $urandom_range(0, w), $urandom_range(0, h), $urandom_range(1, 255));
    end else begin
      // near-identity view, cursor at the viewport center so picks can hit
      write_all(64'd1024, 64'd1024 << 16, 64'd1024 << 48, w, h, w / 2, h / 2,
                $urandom_range(1, 40));
    end
    left = n_items;
    while (left > 0) begin
      int len;
      len = $urandom_range(1, 12);
      if (len > left) len = left;
      for (int i = 0; i < len; i++)
        add_point(rand_coord(spread), rand_coord(spread), rand_coord(spread), i == len - 1);
      left -= len;
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    idle_enable = 1'b1;
    sh_row_x = 64'd1024;
    sh_row_y = 64'd1024 << 16;
    sh_row_w = 64'd1024 << 48;
    sh_width = 14'd1920;
    sh_height = 14'd1080;
    sh_cur_x = '0;
    sh_cur_y = '0;
    sh_radius = 8'd20;
    best_dist = 64'hFFFFFF;
    best_idx = 0;
    have_cand = 1'b0;
    pt_count = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: origin, field extremes, a tie, single-point picks
    add_point(0, 0, 0, 1);
    add_point(-8388608, 0, 0, 1);
    add_point(8388607, 8388607, 8388607, 0);
    add_point(-8388608, -8388608, -8388608, 0);
    add_point(-4096, -4096, 0, 0);
    add_point(-4096, -4096, 0, 1);
    add_point(4096, 4096, 4096, 0);
    add_point(4096, 4096, 4096, 1);
    wait_drained();

    // everything behind the camera: no candidate
    write_all(64'd1024, 64'd1024 << 16, 64'hFC00_0000_0000_0000, 1, 1, 0, 0, 1);
    add_point(100, -100, 5, 0);
    add_point(0, 0, 0, 1);
    add_point(8388607, -8388608, 0, 1);
    wait_drained();

    // register extremes: large viewport, largest cursor, widest radius
    write_all(64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_8000_8000_8000, 64'h7FFF_0001_0001_0001,
              8192, 8192, 8191, 8191, 255);
    add_point(0, 0, 0, 0);
    add_point(-8388608, -8388608, -8388608, 0);
    add_point(8388607, 8388607, 8388607, 0);
    add_point(1, 2, 3, 1);
    wait_drained();
    write_all(64'h0, 64'h0, 64'h0001_0000_0000_0000, 1, 1, 0, 0, 1);
    add_point(5, 5, 5, 0);
    add_point(5, 5, 5, 1);
    wait_drained();

    // long output stall while many short picks queue up
    long_hold_req = 1'b1;
    random_phase(60, 2000);
    long_hold_req = 1'b0;

    for (int ph = 0; ph < 14; ph++) begin
      if (ph == 11) idle_enable = 1'b0;
      random_phase(120, ph % 2 ? 300 : 40000);
    end

    wait_drained();
    if (expected_picks.size() != 0) mismatches++;
    $display("covered %0d points in %0d checked picks (%0d inside the radius),",
             points_sent, picks_checked, found_hits);
    $display("across register extremes, random matrices, stalls and idle gaps");
    if (mismatches == 0) begin
      $display("screen_space_nearest_point_pick_unit verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("screen_space_nearest_point_pick_unit verification failed");
    end
    $finish;
  end
endmodule
